@@ rtl/fdrs_pkg.sv @@
// ----------------------------------------------------------------------------
// fdrs_pkg
// Shared types and codes of the F-LOOK disk request scheduler: operation and
// status codes, controller states, command and status groups.
// ----------------------------------------------------------------------------
package fdrs_pkg;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_SELECT  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_PICK,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic enq_write;
        logic enq_reject;
        logic swap;
        logic report_empty;
        logic scan_start;
        logic scan_step;
        logic pick;
        logic shift_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic op_select;
        logic act_empty;
        logic pend_empty;
        logic pend_full;
        logic scan_last;
        logic shift_done;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/fdrs_ram.sv @@
// ----------------------------------------------------------------------------
// fdrs_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module fdrs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/fdrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// fdrs_ctrl
// Controller of the scheduler: sequences decode, queue scan, pick, removal
// shift and result hand-off for one item at a time.
// ----------------------------------------------------------------------------
module fdrs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  fdrs_pkg::dp_status_t sts,
    output fdrs_pkg::ctrl_cmd_t  cmd
);

    fdrs_pkg::state_t state_reg;
    fdrs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fdrs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fdrs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fdrs_pkg::ST_DECODE;
                end
            end
            fdrs_pkg::ST_DECODE:
            begin
                if (!sts.op_select || (sts.act_empty && sts.pend_empty))
                begin
                    state_next = fdrs_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = fdrs_pkg::ST_SCAN;
                end
            end
            fdrs_pkg::ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = fdrs_pkg::ST_PICK;
                end
            end
            fdrs_pkg::ST_PICK:
            begin
                state_next = fdrs_pkg::ST_SHIFT;
            end
            fdrs_pkg::ST_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    state_next = fdrs_pkg::ST_FINISH;
                end
            end
            fdrs_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = fdrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fdrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            fdrs_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            fdrs_pkg::ST_DECODE:
            begin
                cmd.enq_write    = !sts.op_select && !sts.pend_full;
                cmd.enq_reject   = !sts.op_select && sts.pend_full;
                cmd.swap         = sts.op_select && sts.act_empty && !sts.pend_empty;
                cmd.report_empty = sts.op_select && sts.act_empty && sts.pend_empty;
                cmd.scan_start   = sts.op_select && !(sts.act_empty && sts.pend_empty);
            end
            fdrs_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            fdrs_pkg::ST_PICK:
            begin
                cmd.pick = 1'b1;
            end
            fdrs_pkg::ST_SHIFT:
            begin
                cmd.shift_step = !sts.shift_done;
            end
            fdrs_pkg::ST_FINISH:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/fdrs_datapath.sv @@
// ----------------------------------------------------------------------------
// fdrs_datapath
// Datapath of the scheduler: queue counts and bank select, LOOK scan over
// the active queue, removal shift, result and output registers.
// ----------------------------------------------------------------------------
module fdrs_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TRACK_BITS  = 16,
    parameter int ID_BITS     = 8,
    localparam int IW         = $clog2(QUEUE_DEPTH),
    localparam int CW         = $clog2(QUEUE_DEPTH + 1),
    localparam int AW         = IW + 1,
    localparam int DW         = ID_BITS + TRACK_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fdrs_pkg::ctrl_cmd_t   cmd,
    output fdrs_pkg::dp_status_t  sts,
    input  logic                  operation,
    input  logic [ID_BITS-1:0]    request_id,
    input  logic [TRACK_BITS-1:0] target_track,
    input  logic [TRACK_BITS-1:0] head_track,
    output logic                  ram_we,
    output logic [AW-1:0]         ram_waddr,
    output logic [DW-1:0]         ram_wdata,
    output logic [AW-1:0]         ram_raddr,
    input  logic [DW-1:0]         ram_rdata,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [1:0]            status,
    output logic [ID_BITS-1:0]    chosen_id,
    output logic [TRACK_BITS-1:0] chosen_track,
    output logic                  sweeping_up
);

    // latched item
    logic                  op_reg;
    logic [ID_BITS-1:0]    id_reg;
    logic [TRACK_BITS-1:0] trk_reg;
    logic [TRACK_BITS-1:0] head_reg;

    // queue state
    logic          act_bank_reg, act_bank_next;
    logic [CW-1:0] act_cnt_reg, act_cnt_next;
    logic [CW-1:0] pend_cnt_reg, pend_cnt_next;
    logic          dir_reg, dir_next;

    // scan and shift
    logic [CW-1:0] scan_cnt_reg, scan_cnt_next;
    logic [CW-1:0] shift_cnt_reg, shift_cnt_next;
    logic          sh_wr_vld_reg, sh_wr_vld_next;
    logic [IW-1:0] sh_wr_idx_reg, sh_wr_idx_next;

    logic                  near_found_reg, near_found_next;
    logic [IW-1:0]         near_idx_reg, near_idx_next;
    logic [ID_BITS-1:0]    near_id_reg, near_id_next;
    logic [TRACK_BITS-1:0] near_trk_reg, near_trk_next;
    logic [IW-1:0]         far_idx_reg, far_idx_next;
    logic [ID_BITS-1:0]    far_id_reg, far_id_next;
    logic [TRACK_BITS-1:0] far_trk_reg, far_trk_next;

    // result and output
    logic [1:0]            res_status_reg, res_status_next;
    logic [ID_BITS-1:0]    res_id_reg, res_id_next;
    logic [TRACK_BITS-1:0] res_trk_reg, res_trk_next;
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic [ID_BITS-1:0]    out_id_reg, out_id_next;
    logic [TRACK_BITS-1:0] out_trk_reg, out_trk_next;
    logic                  out_up_reg, out_up_next;

    logic [ID_BITS-1:0]    e_id;
    logic [TRACK_BITS-1:0] e_trk;
    logic [CW-1:0]         pidx_full;
    logic [IW-1:0]         pidx;
    logic                  proc;
    logic                  first;
    logic                  far_better;
    logic                  ahead;
    logic                  near_better;
    logic [IW-1:0]         pick_idx;
    logic [CW-1:0]         shift_prev;
    logic [IW-1:0]         rd_idx;

    assign e_id      = ram_rdata[DW-1:TRACK_BITS];
    assign e_trk     = ram_rdata[TRACK_BITS-1:0];
    assign pidx_full = scan_cnt_reg - CW'(1);
    assign pidx      = pidx_full[IW-1:0];
    assign proc      = cmd.scan_step && (scan_cnt_reg != '0);
    assign first     = (scan_cnt_reg == CW'(1));
    assign far_better  = dir_reg ? (e_trk > far_trk_reg) : (e_trk < far_trk_reg);
    assign ahead       = dir_reg ? (e_trk >= head_reg) : (e_trk <= head_reg);
    assign near_better = !near_found_reg
                       || (dir_reg ? (e_trk < near_trk_reg) : (e_trk > near_trk_reg));
    assign pick_idx    = near_found_reg ? near_idx_reg : far_idx_reg;
    assign shift_prev  = shift_cnt_reg - CW'(1);

    // memory ports
    assign rd_idx    = cmd.shift_step ? shift_cnt_reg[IW-1:0] : scan_cnt_reg[IW-1:0];
    assign ram_raddr = {act_bank_reg, rd_idx};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {act_bank_reg, sh_wr_idx_reg};
        ram_wdata = ram_rdata;
        if (sh_wr_vld_reg)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.enq_write)
        begin
            ram_we    = 1'b1;
            ram_waddr = {~act_bank_reg, pend_cnt_reg[IW-1:0]};
            ram_wdata = {id_reg, trk_reg};
        end
    end

    // status to controller
    always_comb
    begin
        sts.op_select  = (op_reg == fdrs_pkg::OP_SELECT);
        sts.act_empty  = (act_cnt_reg == '0);
        sts.pend_empty = (pend_cnt_reg == '0);
        sts.pend_full  = (pend_cnt_reg == CW'(QUEUE_DEPTH));
        sts.scan_last  = (scan_cnt_reg == act_cnt_reg);
        sts.shift_done = (shift_cnt_reg > act_cnt_reg);
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        act_bank_next   = act_bank_reg;
        act_cnt_next    = act_cnt_reg;
        pend_cnt_next   = pend_cnt_reg;
        dir_next        = dir_reg;
        scan_cnt_next   = scan_cnt_reg;
        shift_cnt_next  = shift_cnt_reg;
        sh_wr_vld_next  = cmd.shift_step;
        sh_wr_idx_next  = shift_prev[IW-1:0];
        near_found_next = near_found_reg;
        near_idx_next   = near_idx_reg;
        near_id_next    = near_id_reg;
        near_trk_next   = near_trk_reg;
        far_idx_next    = far_idx_reg;
        far_id_next     = far_id_reg;
        far_trk_next    = far_trk_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_trk_next    = res_trk_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_trk_next    = out_trk_reg;
        out_up_next     = out_up_reg;

        if (cmd.enq_write)
        begin
            pend_cnt_next   = pend_cnt_reg + CW'(1);
            res_status_next = fdrs_pkg::STATUS_OK;
            res_id_next     = '0;
            res_trk_next    = '0;
        end
        if (cmd.enq_reject)
        begin
            res_status_next = fdrs_pkg::STATUS_FULL;
            res_id_next     = '0;
            res_trk_next    = '0;
        end
        if (cmd.report_empty)
        begin
            res_status_next = fdrs_pkg::STATUS_EMPTY;
            res_id_next     = '0;
            res_trk_next    = '0;
        end
        if (cmd.swap)
        begin
            act_bank_next = ~act_bank_reg;
            act_cnt_next  = pend_cnt_reg;
            pend_cnt_next = '0;
        end
        if (cmd.scan_start)
        begin
            scan_cnt_next   = '0;
            near_found_next = 1'b0;
        end
        if (cmd.scan_step)
        begin
            scan_cnt_next = scan_cnt_reg + CW'(1);
        end
        if (proc)
        begin
            if (first || far_better)
            begin
                far_idx_next = pidx;
                far_id_next  = e_id;
                far_trk_next = e_trk;
            end
            if (ahead && (first || near_better))
            begin
                near_found_next = 1'b1;
                near_idx_next   = pidx;
                near_id_next    = e_id;
                near_trk_next   = e_trk;
            end
        end
        if (cmd.pick)
        begin
            res_status_next = fdrs_pkg::STATUS_OK;
            res_id_next     = near_found_reg ? near_id_reg : far_id_reg;
            res_trk_next    = near_found_reg ? near_trk_reg : far_trk_reg;
            if (!near_found_reg)
            begin
                dir_next = ~dir_reg;
            end
            act_cnt_next   = act_cnt_reg - CW'(1);
            shift_cnt_next = CW'(pick_idx) + CW'(1);
        end
        if (cmd.shift_step)
        begin
            shift_cnt_next = shift_cnt_reg + CW'(1);
        end
        if (cmd.load_out)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_id_next     = res_id_reg;
            out_trk_next    = res_trk_reg;
            out_up_next     = dir_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_bank_reg  <= 1'b0;
            act_cnt_reg   <= '0;
            pend_cnt_reg  <= '0;
            dir_reg       <= 1'b1;
            scan_cnt_reg  <= '0;
            shift_cnt_reg <= '0;
            sh_wr_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_bank_reg  <= act_bank_next;
            act_cnt_reg   <= act_cnt_next;
            pend_cnt_reg  <= pend_cnt_next;
            dir_reg       <= dir_next;
            scan_cnt_reg  <= scan_cnt_next;
            shift_cnt_reg <= shift_cnt_next;
            sh_wr_vld_reg <= sh_wr_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= operation;
            id_reg   <= request_id;
            trk_reg  <= target_track;
            head_reg <= head_track;
        end
        sh_wr_idx_reg  <= sh_wr_idx_next;
        near_found_reg <= near_found_next;
        near_idx_reg   <= near_idx_next;
        near_id_reg    <= near_id_next;
        near_trk_reg   <= near_trk_next;
        far_idx_reg    <= far_idx_next;
        far_id_reg     <= far_id_next;
        far_trk_reg    <= far_trk_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_trk_reg    <= res_trk_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_trk_reg    <= out_trk_next;
        out_up_reg     <= out_up_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign chosen_id    = out_id_reg;
    assign chosen_track = out_trk_reg;
    assign sweeping_up  = out_up_reg;

endmodule

@@ rtl/flook_disk_request_scheduler_top.sv @@
// Steps: an enqueue passes decode and result load; a select on empty queues likewise;
// a select with active entries passes decode, the scan (one compare per RAM read),
// pick, the removal shift of the entries behind the pick, result load and output.
// Throughput: one item at a time; the scan and shift over the single queue RAM set it.
// Reset: asynchronous, active low; both queues empty, sweep upward, no result pending.
// ----------------------------------------------------------------------------
// flook_disk_request_scheduler_top
// F-LOOK disk request scheduler: pending and active queues in one two-bank
// RAM, LOOK pick over the active queue, ordered removal.
// ----------------------------------------------------------------------------
module flook_disk_request_scheduler_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TRACK_BITS  = 16,
    parameter int ID_BITS     = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic [ID_BITS-1:0]    request_id,
    input  logic [TRACK_BITS-1:0] target_track,
    input  logic [TRACK_BITS-1:0] head_track,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [ID_BITS-1:0]    chosen_id,
    output logic [TRACK_BITS-1:0] chosen_track,
    output logic                  sweeping_up
);

    localparam int AW = $clog2(QUEUE_DEPTH) + 1;
    localparam int DW = ID_BITS + TRACK_BITS;

    fdrs_pkg::ctrl_cmd_t  cmd;
    fdrs_pkg::dp_status_t sts;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    fdrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    fdrs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TRACK_BITS  (TRACK_BITS),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .operation    (operation),
        .request_id   (request_id),
        .target_track (target_track),
        .head_track   (head_track),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .status       (status),
        .chosen_id    (chosen_id),
        .chosen_track (chosen_track),
        .sweeping_up  (sweeping_up)
    );

    fdrs_ram #(
        .WIDTH (DW),
        .DEPTH (1 << AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

@@ rtl/fdrs_checker.sv @@
// ----------------------------------------------------------------------------
// fdrs_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module fdrs_checker #(
    parameter int TRACK_BITS = 16,
    parameter int ID_BITS    = 8
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [1:0]            status,
    input logic [ID_BITS-1:0]    chosen_id,
    input logic [TRACK_BITS-1:0] chosen_track,
    input logic                  sweeping_up
);

    // one item in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(chosen_id)
            && $stable(chosen_track) && $stable(sweeping_up))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == fdrs_pkg::STATUS_OK || status == fdrs_pkg::STATUS_EMPTY
            || status == fdrs_pkg::STATUS_FULL))
        else $error("undefined status code");

    a_no_choice_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != fdrs_pkg::STATUS_OK |-> chosen_id == '0 && chosen_track == '0)
        else $error("chosen fields set on a failed item");

endmodule

bind flook_disk_request_scheduler_top fdrs_checker #(
    .TRACK_BITS (TRACK_BITS),
    .ID_BITS    (ID_BITS)
) u_fdrs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .chosen_id    (chosen_id),
    .chosen_track (chosen_track),
    .sweeping_up  (sweeping_up)
);
